// ----- hdl/lclz2_pkg.sv -----
`timescale 1ns / 1ps

package lclz2_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int BURST_MAX  = 64;
    localparam int K_W        = $clog2(BURST_MAX + 1);
    localparam int WP_W       = 17;
    localparam int POS_W      = 16;
    localparam int LEN_W      = 11;
    localparam int SRC_W      = 16;

    localparam logic [WP_W-1:0] LIMIT_CAP = 17'h10000;
    localparam logic [7:0]      BYTE_END  = 8'hFF;

    localparam logic [2:0] CMD_COPY      = 3'd0;
    localparam logic [2:0] CMD_BFILL     = 3'd1;
    localparam logic [2:0] CMD_WFILL     = 3'd2;
    localparam logic [2:0] CMD_IFILL     = 3'd3;
    localparam logic [2:0] CMD_REPEAT    = 3'd4;
    localparam logic [2:0] CMD_FIRST_BAD = 3'd5;
    localparam logic [2:0] CMD_LONG      = 3'd7;

    localparam logic ITEM_STREAM = 1'b0;
    localparam logic ITEM_CONT   = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNKNOWN,
        ERR_PENDING,
        ERR_LIMIT
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LONGLEN,
        PH_COPY,
        PH_FILL1,
        PH_FILL2,
        PH_SRCHI,
        PH_SRCLO,
        PH_RUN
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DECODE,
        C_FILL,
        C_READ,
        C_WRITE
    } ctl_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        logic [POS_W-1:0]  position;
        err_t              err;
        logic              run_done;
        logic              last;
    } res_t;

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [HIST_AW-1:0] raddr;
    } hist_req_t;

    function automatic res_t mk_res(kind_t kind, logic [7:0] data,
                                    logic [POS_W-1:0] position, err_t err,
                                    logic run_done, logic last);
        res_t r;
        r.kind     = kind;
        r.data     = data;
        r.position = position;
        r.err      = err;
        r.run_done = run_done;
        r.last     = last;
        return r;
    endfunction

endpackage

// ----- hdl/lclz2_history.sv -----
`timescale 1ns / 1ps

module lclz2_history (
    input  logic                    aclk,
    input  lclz2_pkg::hist_req_t    req_i,
    input  logic [lclz2_pkg::WP_W-1:0] wp_i,
    output logic [7:0]              rdata_o
);
    import lclz2_pkg::*;

    logic [7:0] mem [HIST_DEPTH];
    logic [7:0] mem_q_reg;
    logic       ok_reg;

    always_ff @(posedge aclk) begin
        if (req_i.we) begin
            mem[req_i.waddr] <= req_i.wdata;
        end
    end

    // entries at or above the fill count have never been written and read as zero
    always_ff @(posedge aclk) begin
        if (req_i.re) begin
            mem_q_reg <= mem[req_i.raddr];
            ok_reg    <= (wp_i >= WP_W'(HIST_DEPTH)) || (WP_W'(req_i.raddr) < wp_i);
        end
    end

    assign rdata_o = ok_reg ? mem_q_reg : 8'h00;

endmodule

// ----- hdl/lclz2_out_reg.sv -----
`timescale 1ns / 1ps

module lclz2_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  lclz2_pkg::res_t   res_i,
    input  logic              m_ready_i,
    output logic              m_valid_o,
    output lclz2_pkg::res_t   res_o,
    output logic              free_o
);
    import lclz2_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign free_o     = !valid_reg || m_ready_i;
    assign valid_next = push_i ? 1'b1 : (m_ready_i ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            res_reg <= res_i;
        end
    end

    assign m_valid_o = valid_reg;
    assign res_o     = res_reg;

endmodule

// ----- hdl/lclz2_engine.sv -----
`timescale 1ns / 1ps

module lclz2_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid_i,
    output logic                        s_ready_o,
    input  logic                        s_cmd_i,
    input  logic [7:0]                  s_in_byte_i,
    input  logic [lclz2_pkg::WP_W-1:0]  max_output_i,
    input  logic                        out_free_i,
    output logic                        push_o,
    output lclz2_pkg::res_t             res_o,
    output lclz2_pkg::hist_req_t        hreq_o,
    output logic [lclz2_pkg::WP_W-1:0]  wp_o,
    input  logic [7:0]                  rdata_i
);
    import lclz2_pkg::*;

    ctl_t              ctl_reg, ctl_next;
    phase_t            phase_reg, phase_next;
    logic              finished_reg, finished_next;
    logic [WP_W-1:0]   wp_reg, wp_next;
    logic [2:0]        kind_reg, kind_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic [LEN_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [7:0]        fill1_reg, fill1_next;
    logic [7:0]        fill2_reg, fill2_next;
    logic [SRC_W-1:0]  src_reg, src_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              item_cmd_reg, item_cmd_next;
    logic [7:0]        item_byte_reg, item_byte_next;

    logic [WP_W-1:0]   limit;
    logic              at_limit;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  run_cnt_inc;
    logic              run_end;
    logic [K_W-1:0]    k_inc;
    logic              burst_end;
    logic [2:0]        hdr_cmd;
    logic              dec_emit;
    logic              do_start;
    logic [2:0]        sc_kind;
    logic [LEN_W-1:0]  sc_len;
    logic              start_burst;
    logic              data_go;
    logic [7:0]        data_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= C_IDLE;
            phase_reg    <= PH_HEADER;
            finished_reg <= 1'b0;
            wp_reg       <= '0;
            kind_reg     <= '0;
            run_len_reg  <= '0;
            run_cnt_reg  <= '0;
            fill1_reg    <= '0;
            fill2_reg    <= '0;
            src_reg      <= '0;
            k_reg        <= '0;
        end else begin
            ctl_reg      <= ctl_next;
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
            wp_reg       <= wp_next;
            kind_reg     <= kind_next;
            run_len_reg  <= run_len_next;
            run_cnt_reg  <= run_cnt_next;
            fill1_reg    <= fill1_next;
            fill2_reg    <= fill2_next;
            src_reg      <= src_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_cmd_reg  <= item_cmd_next;
        item_byte_reg <= item_byte_next;
    end

    always_comb begin
        ctl_next       = ctl_reg;
        phase_next     = phase_reg;
        finished_next  = finished_reg;
        wp_next        = wp_reg;
        kind_next      = kind_reg;
        run_len_next   = run_len_reg;
        run_cnt_next   = run_cnt_reg;
        fill1_next     = fill1_reg;
        fill2_next     = fill2_reg;
        src_next       = src_reg;
        k_next         = k_reg;
        item_cmd_next  = item_cmd_reg;
        item_byte_next = item_byte_reg;

        s_ready_o   = 1'b0;
        push_o      = 1'b0;
        res_o       = '0;
        hreq_o      = '0;
        hreq_o.waddr = wp_reg[HIST_AW-1:0];
        hreq_o.raddr = src_reg[HIST_AW-1:0];

        limit       = (max_output_i > LIMIT_CAP) ? LIMIT_CAP : max_output_i;
        at_limit    = wp_reg >= limit;
        pos         = wp_reg[POS_W-1:0];
        run_cnt_inc = run_cnt_reg + LEN_W'(1);
        run_end     = run_cnt_inc >= run_len_reg;
        k_inc       = k_reg + K_W'(1);
        burst_end   = k_inc == K_W'(BURST_MAX);
        hdr_cmd     = item_byte_reg[7:5];

        dec_emit    = 1'b0;
        do_start    = 1'b0;
        sc_kind     = kind_reg;
        sc_len      = run_len_reg;
        start_burst = 1'b0;
        data_go     = 1'b0;
        data_val    = fill1_reg;

        case (ctl_reg)
            C_IDLE: begin
                s_ready_o = 1'b1;
                if (s_valid_i) begin
                    item_cmd_next  = s_cmd_i;
                    item_byte_next = s_in_byte_i;
                    ctl_next       = C_DECODE;
                end
            end

            C_DECODE: begin
                if (!finished_reg && item_cmd_reg == ITEM_STREAM) begin
                    case (phase_reg)
                        PH_HEADER: dec_emit = (item_byte_reg == BYTE_END) || at_limit ||
                                              (hdr_cmd != CMD_LONG && hdr_cmd >= CMD_FIRST_BAD);
                        PH_LONGLEN: dec_emit = kind_reg >= CMD_FIRST_BAD;
                        PH_COPY:    dec_emit = 1'b1;
                        PH_RUN:     dec_emit = 1'b1;
                        default:    dec_emit = 1'b0;
                    endcase
                end
                if (!dec_emit || out_free_i) begin
                    ctl_next = C_IDLE;
                    if (finished_reg) begin
                        // drop
                    end else if (item_cmd_reg == ITEM_CONT) begin
                        start_burst = phase_reg == PH_RUN;
                    end else begin
                        case (phase_reg)
                            PH_HEADER: begin
                                if (item_byte_reg == BYTE_END) begin
                                    push_o        = 1'b1;
                                    res_o         = mk_res(KIND_END, 8'h00, pos, ERR_NONE,
                                                           1'b0, 1'b1);
                                    finished_next = 1'b1;
                                end else if (at_limit) begin
                                    push_o        = 1'b1;
                                    res_o         = mk_res(KIND_ERROR, 8'h00, pos, ERR_LIMIT,
                                                           1'b0, 1'b1);
                                    finished_next = 1'b1;
                                    phase_next    = PH_HEADER;
                                end else if (hdr_cmd == CMD_LONG) begin
                                    kind_next    = item_byte_reg[4:2];
                                    run_len_next = LEN_W'({item_byte_reg[1:0], 8'h00});
                                    phase_next   = PH_LONGLEN;
                                end else begin
                                    do_start = 1'b1;
                                    sc_kind  = hdr_cmd;
                                    sc_len   = LEN_W'(item_byte_reg[4:0]) + LEN_W'(1);
                                end
                            end
                            PH_LONGLEN: begin
                                do_start = 1'b1;
                                sc_kind  = kind_reg;
                                sc_len   = LEN_W'({run_len_reg[9:8], item_byte_reg}) +
                                           LEN_W'(1);
                            end
                            PH_COPY: begin
                                if (at_limit) begin
                                    push_o        = 1'b1;
                                    res_o         = mk_res(KIND_ERROR, 8'h00, pos, ERR_LIMIT,
                                                           1'b0, 1'b1);
                                    finished_next = 1'b1;
                                    phase_next    = PH_HEADER;
                                end else begin
                                    hreq_o.we    = 1'b1;
                                    hreq_o.wdata = item_byte_reg;
                                    push_o       = 1'b1;
                                    res_o        = mk_res(KIND_DATA, item_byte_reg, pos,
                                                          ERR_NONE, run_end, 1'b1);
                                    wp_next      = wp_reg + WP_W'(1);
                                    run_cnt_next = run_cnt_inc;
                                    if (run_end) begin
                                        phase_next = PH_HEADER;
                                    end
                                end
                            end
                            PH_FILL1: begin
                                fill1_next = item_byte_reg;
                                if (kind_reg == CMD_WFILL) begin
                                    phase_next = PH_FILL2;
                                end else begin
                                    start_burst = 1'b1;
                                end
                            end
                            PH_FILL2: begin
                                fill2_next  = item_byte_reg;
                                start_burst = 1'b1;
                            end
                            PH_SRCHI: begin
                                src_next   = {item_byte_reg, 8'h00};
                                phase_next = PH_SRCLO;
                            end
                            PH_SRCLO: begin
                                src_next    = {src_reg[15:8], item_byte_reg};
                                start_burst = 1'b1;
                            end
                            PH_RUN: begin
                                push_o = 1'b1;
                                res_o  = mk_res(KIND_ERROR, 8'h00, pos, ERR_PENDING,
                                                1'b0, 1'b1);
                            end
                            default: ;
                        endcase
                    end
                end
            end

            C_FILL: begin
                if (out_free_i) begin
                    if (at_limit) begin
                        push_o        = 1'b1;
                        res_o         = mk_res(KIND_ERROR, 8'h00, pos, ERR_LIMIT, 1'b0, 1'b1);
                        finished_next = 1'b1;
                        phase_next    = PH_HEADER;
                        ctl_next      = C_IDLE;
                    end else begin
                        data_go = 1'b1;
                        case (kind_reg)
                            CMD_WFILL: data_val = run_cnt_reg[0] ? fill2_reg : fill1_reg;
                            CMD_IFILL: data_val = fill1_reg + run_cnt_reg[7:0];
                            default:   data_val = fill1_reg;
                        endcase
                    end
                end
            end

            C_READ: begin
                if (at_limit) begin
                    if (out_free_i) begin
                        push_o        = 1'b1;
                        res_o         = mk_res(KIND_ERROR, 8'h00, pos, ERR_LIMIT, 1'b0, 1'b1);
                        finished_next = 1'b1;
                        phase_next    = PH_HEADER;
                        ctl_next      = C_IDLE;
                    end
                end else begin
                    hreq_o.re = 1'b1;
                    ctl_next  = C_WRITE;
                end
            end

            C_WRITE: begin
                if (out_free_i) begin
                    data_go  = 1'b1;
                    data_val = rdata_i;
                    src_next = src_reg + SRC_W'(1);
                end
            end

            default: ctl_next = C_IDLE;
        endcase

        if (do_start) begin
            kind_next    = sc_kind;
            run_len_next = sc_len;
            run_cnt_next = '0;
            case (sc_kind)
                CMD_COPY:   phase_next = PH_COPY;
                CMD_BFILL:  phase_next = PH_FILL1;
                CMD_WFILL:  phase_next = PH_FILL1;
                CMD_IFILL:  phase_next = PH_FILL1;
                CMD_REPEAT: phase_next = PH_SRCHI;
                default: begin
                    phase_next = PH_HEADER;
                    push_o     = 1'b1;
                    res_o      = mk_res(KIND_ERROR, 8'h00, pos, ERR_UNKNOWN, 1'b0, 1'b1);
                end
            endcase
        end

        if (start_burst) begin
            phase_next = PH_RUN;
            k_next     = '0;
            ctl_next   = (kind_reg == CMD_REPEAT) ? C_READ : C_FILL;
        end

        if (data_go) begin
            hreq_o.we    = 1'b1;
            hreq_o.wdata = data_val;
            push_o       = 1'b1;
            res_o        = mk_res(KIND_DATA, data_val, pos, ERR_NONE, run_end,
                                  run_end || burst_end);
            wp_next      = wp_reg + WP_W'(1);
            run_cnt_next = run_cnt_inc;
            k_next       = k_inc;
            if (run_end) begin
                phase_next = PH_HEADER;
                ctl_next   = C_IDLE;
            end else if (burst_end) begin
                ctl_next = C_IDLE;
            end else begin
                ctl_next = (kind_reg == CMD_REPEAT) ? C_READ : C_FILL;
            end
        end
    end

    assign wp_o = wp_reg;

endmodule

// ----- hdl/lc_lz2_decompressor_core.sv -----
// Sequencing: decode runs in the cycle after acceptance and registers a header, copy or
// error result at its end; a fill byte comes from the fill state, a repeat byte from a
// history read, then write-back. A new item is taken only in the idle state, never
// mid-burst; bursts of up to 64; m_ready low with a result held stalls the engine.
// Reset: aresetn, synchronous, active low; history reads as zero until written,
// tracked by the write position, so no clearing pass is needed.
`timescale 1ns / 1ps

module lc_lz2_decompressor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_out_position,
    output logic [1:0]  m_error_code,
    output logic        m_run_done,
    output logic        m_last
);
    import lclz2_pkg::*;

    logic [WP_W-1:0] max_output_reg;
    logic            out_free;
    logic            eng_push;
    res_t            eng_res;
    res_t            out_res;
    hist_req_t       hist_req;
    logic [WP_W-1:0] wp;
    logic [7:0]      hist_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_output_reg <= LIMIT_CAP;
        end else if (cfg_wr_en) begin
            max_output_reg <= cfg_wr_data;
        end
    end

    lclz2_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid_i    (s_valid),
        .s_ready_o    (s_ready),
        .s_cmd_i      (s_cmd),
        .s_in_byte_i  (s_in_byte),
        .max_output_i (max_output_reg),
        .out_free_i   (out_free),
        .push_o       (eng_push),
        .res_o        (eng_res),
        .hreq_o       (hist_req),
        .wp_o         (wp),
        .rdata_i      (hist_rdata)
    );

    lclz2_history u_history (
        .aclk    (aclk),
        .req_i   (hist_req),
        .wp_i    (wp),
        .rdata_o (hist_rdata)
    );

    lclz2_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (eng_push),
        .res_i     (eng_res),
        .m_ready_i (m_ready),
        .m_valid_o (m_valid),
        .res_o     (out_res),
        .free_o    (out_free)
    );

    assign m_kind         = out_res.kind;
    assign m_out_byte     = out_res.data;
    assign m_out_position = out_res.position;
    assign m_error_code   = out_res.err;
    assign m_run_done     = out_res.run_done;
    assign m_last         = out_res.last;

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_push |-> out_free)
        else $error("result pushed into a full output register");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction taken before decode");

    a_read_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_req.re |=> !hist_req.re)
        else $error("back-to-back history reads without write-back");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_req.we |-> (wp < LIMIT_CAP))
        else $error("history write beyond capacity");

endmodule
